// ----- hw/rtl/scfr_pkg.sv -----
// Shared types and constants for the sum-checked frame receiver.
`timescale 1ns / 1ps
package scfr_pkg;

	localparam int DEFAULT_MAX_PAYLOAD = 32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;

	localparam logic [7:0] FIRST_SYNC_RESET  = 8'd170;
	localparam logic [7:0] SECOND_SYNC_RESET = 8'd175;

	localparam int FUNC_W   = 8;
	localparam int FLEN_W   = 6;
	localparam int BIDX_W   = 5;
	localparam int BYTE_W   = 8;
	localparam int M_DATA_W = 32;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_FUNC  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHK   = 3'd5
	} phase_t;

	typedef struct packed {
		logic       start;
		logic [7:0] func;
		logic [7:0] len;
	} frame_start_t;

endpackage

// ----- hw/rtl/sum_checked_frame_receiver.sv -----
// Top level of the sum-checked frame receiver.
//
// Received bytes enter on the s_axis channel, one byte per transfer in s_tdata.
// The block hunts for two sync bytes, takes a function id and a length, stores
// the payload bytes and tests an 8-bit wrapping checksum. While a frame is being
// received s_tready stays high, so every byte is taken as it is offered.
// After a good checksum byte the frame is read back from the payload store and
// sent on the m_axis channel, one transfer per payload byte, or one transfer
// with m_tuser low for an empty frame; m_tlast marks the final one. The first
// result passes through the read sequencer, the store's registered read port
// and the output register; with m_tready held high one result follows per
// cycle. s_tready stays low while the store is being read, that is until the
// last entry (the only entry of an empty frame) has been read, including any
// stall by m_tready; the store has one read port. Bad frames produce nothing.
// The cfg channel writes the sync byte registers (index 0 first, index 1
// second) and is always ready. Reset puts the parser back into the sync hunt
// and loads the sync registers with 0xAA and 0xAF.
`timescale 1ns / 1ps
module sum_checked_frame_receiver import scfr_pkg::*; #(
	parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // [7:0] frame_func, [13:8] frame_length,
	                                        // [18:14] byte_index, [26:19] payload_byte
	output logic                 m_tuser,   // [0] has_payload
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]   first_sync_q;
	logic [7:0]   second_sync_q;
	logic         in_acc;
	logic         busy;
	frame_start_t start;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]   wr_data;
	logic         rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]   rd_data;
	logic [FUNC_W-1:0] o_func;
	logic [FLEN_W-1:0] o_len;
	logic [BIDX_W-1:0] o_idx;
	logic [BYTE_W-1:0] o_byte;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy;
	assign in_acc    = s_tvalid && s_tready;
	assign m_tdata   = {5'b0, o_byte, o_idx, o_len, o_func};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RESET;
			second_sync_q <= SECOND_SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				CFG_SECOND_SYNC: second_sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.in_byte     (s_tdata),
		.first_sync  (first_sync_q),
		.second_sync (second_sync_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.start       (start)
	);

	scfr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	scfr_readout #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_readout (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_func  (o_func),
		.out_len   (o_len),
		.out_idx   (o_idx),
		.out_byte  (o_byte),
		.out_has   (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ----- hw/rtl/scfr_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module scfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/scfr_parser.sv -----
// Frame parser: sync hunt, header capture, payload store writes and checksum test.
`timescale 1ns / 1ps
module scfr_parser import scfr_pkg::*; #(
	parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
	localparam int LW = $clog2(MAX_PAYLOAD + 1),
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_acc,
	input  logic [7:0]   in_byte,
	input  logic [7:0]   first_sync,
	input  logic [7:0]   second_sync,
	output logic         wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]   wr_data,
	output frame_start_t start
);

	localparam logic [7:0] MAX_LEN_B = 8'(MAX_PAYLOAD);

	phase_t phase_q, phase_d;
	logic [7:0]    func_q, func_d;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] fill_q, fill_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    chk_sum;

	assign chk_sum = first_sync + second_sync + sum_q;
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			func_q  <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			func_q  <= func_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		func_d      = func_q;
		len_d       = len_q;
		fill_d      = fill_q;
		sum_d       = sum_q;
		wr_en       = 1'b0;
		start.start = 1'b0;
		start.func  = func_q;
		start.len   = 8'(len_q);
		if (in_acc) begin
			case (phase_q)
				PH_SYNC2: begin
					phase_d = (in_byte == second_sync) ? PH_FUNC : PH_SYNC1;
				end
				PH_FUNC: begin
					func_d  = in_byte;
					sum_d   = in_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					if (in_byte <= MAX_LEN_B) begin
						len_d   = LW'(in_byte);
						fill_d  = '0;
						sum_d   = sum_q + in_byte;
						phase_d = (in_byte != 8'd0) ? PH_DATA : PH_CHK;
					end else begin
						phase_d = PH_SYNC1;
					end
				end
				PH_DATA: begin
					wr_en  = 1'b1;
					sum_d  = sum_q + in_byte;
					fill_d = fill_q + 1'b1;
					if (fill_d == len_q) begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					start.start = (chk_sum == in_byte);
					phase_d     = PH_SYNC1;
				end
				default: begin
					phase_d = (in_byte == first_sync) ? PH_SYNC2 : PH_SYNC1;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/scfr_readout.sv -----
// Readout sequencer: reads the payload store and drives the result register.
`timescale 1ns / 1ps
module scfr_readout import scfr_pkg::*; #(
	parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD,
	localparam int LW = $clog2(MAX_PAYLOAD + 1),
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frame_start_t      start,
	output logic              busy,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [7:0]        rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FUNC_W-1:0] out_func,
	output logic [FLEN_W-1:0] out_len,
	output logic [BIDX_W-1:0] out_idx,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_has,
	output logic              out_last
);

	logic          rd_active_q;
	logic [LW-1:0] rd_idx_q;
	logic [LW-1:0] rd_len_q;
	logic [7:0]    rd_func_q;
	logic          rd_last;

	logic          v_s1;
	logic [LW-1:0] idx_s1;
	logic [LW-1:0] len_s1;
	logic [7:0]    func_s1;
	logic          last_s1;
	logic          has_s1;
	logic          adv_s1;

	logic          out_v_q;

	assign busy    = rd_active_q;
	assign rd_last = (rd_len_q == '0) || (LW'(rd_idx_q + 1'b1) == rd_len_q);
	assign adv_s1  = v_s1 && (!out_v_q || out_ready);
	assign rd_en   = rd_active_q && (!v_s1 || adv_s1);
	assign rd_addr = rd_idx_q[AW-1:0];
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_active_q <= 1'b0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (start.start) begin
				rd_active_q <= 1'b1;
				rd_idx_q    <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_last) begin
					rd_active_q <= 1'b0;
				end
			end
			if (rd_en) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start.start) begin
			rd_len_q  <= LW'(start.len);
			rd_func_q <= start.func;
		end
		if (rd_en) begin
			idx_s1  <= rd_idx_q;
			len_s1  <= rd_len_q;
			func_s1 <= rd_func_q;
			last_s1 <= rd_last;
			has_s1  <= (rd_len_q != '0);
		end
		if (adv_s1) begin
			out_func <= func_s1;
			out_len  <= FLEN_W'(len_s1);
			out_idx  <= BIDX_W'(idx_s1);
			out_byte <= has_s1 ? rd_data : 8'd0;
			out_has  <= has_s1;
			out_last <= last_s1;
		end
	end

`ifndef SYNTHESIS
	ap_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start.start |-> !rd_active_q)
		else $error("frame start while readout still active");

	ap_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(idx_s1))
		else $error("read stage lost its item while stalled");

	ap_last_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_last && !start.start |=> !rd_active_q)
		else $error("readout continued past the last entry");

	ap_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_has |-> out_last && out_idx == '0)
		else $error("empty-frame result not marked last");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the sum-checked frame receiver: directed and random frames.
`timescale 1ns / 1ps
module tb_top;
	import scfr_pkg::*;

	localparam int PAYLOAD_CAP = DEFAULT_MAX_PAYLOAD;
	localparam int IDLE_LIMIT  = 2000;

	typedef struct {
		logic [7:0] func;
		logic [5:0] flen;
		logic [4:0] idx;
		logic [7:0] value;
		logic       has;
		logic       fin;
	} beat_t;

	typedef enum {FR_GOOD, FR_BAD_SUM, FR_CUT} frame_kind_t;

	class frame_tracker;
		logic [7:0]  sync_a;
		logic [7:0]  sync_b;
		phase_t      phase;
		logic [7:0]  func_q;
		logic [5:0]  len_q;
		logic [5:0]  fill_q;
		logic [7:0]  sum_q;
		logic [7:0]  store [PAYLOAD_CAP];
		beat_t       beats_owed [$];
		int unsigned errors;

		function new();
			sync_a = FIRST_SYNC_RESET;
			sync_b = SECOND_SYNC_RESET;
			phase = PH_SYNC1;
			func_q = '0;
			len_q = '0;
			fill_q = '0;
			sum_q = '0;
			errors = 0;
		endfunction

		function void set_sync(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == CFG_FIRST_SYNC)
				sync_a = val;
			else if (idx == CFG_SECOND_SYNC)
				sync_b = val;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			logic [7:0] total;
			beat_t      beat;
			int         i;
			case (phase)
				PH_SYNC2: begin
					if (b == sync_b)
						phase = PH_FUNC;
					else
						phase = PH_SYNC1;
				end
				PH_FUNC: begin
					func_q = b;
					sum_q = b;
					phase = PH_LEN;
				end
				PH_LEN: begin
					if (b <= PAYLOAD_CAP) begin
						len_q = b[5:0];
						fill_q = '0;
						sum_q = sum_q + b;
						if (b != 0)
							phase = PH_DATA;
						else
							phase = PH_CHK;
					end else begin
						phase = PH_SYNC1;
					end
				end
				PH_DATA: begin
					if (fill_q < PAYLOAD_CAP)
						store[fill_q[4:0]] = b;
					sum_q = sum_q + b;
					fill_q = fill_q + 1'b1;
					if (fill_q >= len_q)
						phase = PH_CHK;
				end
				PH_CHK: begin
					total = sync_a + sync_b + sum_q;
					if (total == b) begin
						beat.func = func_q;
						if (len_q == 0) begin
							beat.flen = '0;
							beat.idx = '0;
							beat.value = '0;
							beat.has = 1'b0;
							beat.fin = 1'b1;
							beats_owed.push_back(beat);
						end else begin
							for (i = 0; i < len_q && i < PAYLOAD_CAP; i++) begin
								beat.flen = len_q;
								beat.idx = i[4:0];
								beat.value = store[i];
								beat.has = 1'b1;
								beat.fin = (i + 1 == len_q);
								beats_owed.push_back(beat);
							end
						end
					end
					phase = PH_SYNC1;
				end
				default: begin
					if (b == sync_a)
						phase = PH_SYNC2;
					else
						phase = PH_SYNC1;
				end
			endcase
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_beat(logic [M_DATA_W-1:0] d, logic user, logic lastb);
			beat_t want;
			if (beats_owed.size() == 0) begin
				errors++;
				$display("%0t: output transfer with no frame pending, expected none, actual %h",
					$time, d);
				return;
			end
			want = beats_owed.pop_front();
			report("frame_func", want.func, d[7:0]);
			report("frame_length", want.flen, d[13:8]);
			report("byte_index", want.idx, d[18:14]);
			report("payload_byte", want.value, d[26:19]);
			report("tdata padding", 0, d[M_DATA_W-1:27]);
			report("has_payload", want.has, user);
			report("last", want.fin, lastb);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	frame_tracker tracker;
	logic [7:0]   cur_sync_a;
	logic [7:0]   cur_sync_b;
	int unsigned  rx_sent;
	int unsigned  send_calm;
	int unsigned  recv_calm;
	int unsigned  out_hold;
	int unsigned  quiet_cycles;

	sum_checked_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned draw_wait(ref int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] rand_payload();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return PAYLOAD_CAP;
		if (r < 3)
			return $urandom_range(7, PAYLOAD_CAP - 1);
		return $urandom_range(0, 6);
	endfunction

	always @(negedge clk) begin
		if (out_hold > 0) begin
			m_tready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_beat(m_tdata, m_tuser, m_tlast);
			out_hold <= draw_wait(recv_calm);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_rx(input logic [7:0] b);
		int unsigned gap;
		gap = draw_wait(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_rx_byte(b);
		rx_sent++;
	endtask

	task automatic send_frame(input logic [7:0] func, input int len, input frame_kind_t kind);
		logic [7:0] chk;
		logic [7:0] b;
		int         keep;
		int         i;
		chk = cur_sync_a + cur_sync_b + func + len[7:0];
		keep = (kind == FR_CUT && len > 0) ? $urandom_range(0, len - 1) : len;
		send_rx(cur_sync_a);
		send_rx(cur_sync_b);
		send_rx(func);
		send_rx(len[7:0]);
		if (len > PAYLOAD_CAP)
			return;
		for (i = 0; i < keep; i++) begin
			b = rand_payload();
			chk = chk + b;
			send_rx(b);
		end
		if (kind == FR_CUT)
			return;
		if (kind == FR_BAD_SUM)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_rx(chk);
	endtask

	task automatic random_traffic(input int unsigned upto);
		int unsigned pick;
		while (rx_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_frame(8'($urandom), pick_len(), FR_GOOD);
			end else if (pick < 75) begin
				send_frame(8'($urandom), pick_len(), FR_BAD_SUM);
			end else if (pick < 80) begin
				send_frame(8'($urandom), $urandom_range(PAYLOAD_CAP + 1, 255), FR_GOOD);
			end else if (pick < 86) begin
				send_rx(cur_sync_a);
				send_rx(8'($urandom));
			end else if (pick < 92) begin
				send_frame(8'($urandom), $urandom_range(1, 8), FR_CUT);
			end else begin
				repeat ($urandom_range(1, 6)) send_rx(8'($urandom));
			end
		end
	endtask

	// Feeds bytes that cannot start a frame until the parser is back in the sync hunt.
	task automatic resync();
		logic [7:0] filler;
		filler = (cur_sync_a != 8'hC3) ? 8'hC3 : 8'h3C;
		while (tracker.phase != PH_SYNC1)
			send_rx(filler);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (tracker.beats_owed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_sync(idx, val);
		if (idx == CFG_FIRST_SYNC)
			cur_sync_a = val;
		else
			cur_sync_b = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [7:0] p0;
		logic [7:0] p1;
		tracker = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_SYNC;
		cfg_data = '0;
		out_hold = 0;
		send_calm = 0;
		recv_calm = 0;
		quiet_cycles = 0;
		rx_sent = 0;
		cur_sync_a = FIRST_SYNC_RESET;
		cur_sync_b = SECOND_SYNC_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty frame with the largest function id.
		send_frame(8'hFF, 0, FR_GOOD);
		// A length byte equal to the first sync byte drops the frame and must not
		// restart the header; the bytes after it would form a good empty frame.
		send_rx(cur_sync_a);
		send_rx(cur_sync_b);
		send_rx(8'h12);
		send_rx(cur_sync_a);
		send_rx(cur_sync_b);
		send_rx(8'h07);
		send_rx(8'h00);
		send_rx(cur_sync_a + cur_sync_b + 8'h07);
		// A failed second sync byte is not taken as a new first sync byte.
		send_rx(cur_sync_a);
		send_rx(cur_sync_a);
		send_rx(cur_sync_b);
		send_rx(8'h09);
		send_rx(8'h00);
		send_rx(cur_sync_a + cur_sync_b + 8'h09);
		send_frame(8'h00, 1, FR_BAD_SUM);

		send_frame(8'h00, PAYLOAD_CAP, FR_GOOD);
		random_traffic(110);

		settle();
		write_sync(CFG_FIRST_SYNC, 8'h00);
		write_sync(CFG_SECOND_SYNC, 8'hFF);
		resync();
		random_traffic(180);

		settle();
		write_sync(CFG_FIRST_SYNC, 8'hFF);
		write_sync(CFG_SECOND_SYNC, 8'h00);
		resync();
		send_frame(8'hFF, PAYLOAD_CAP, FR_GOOD);
		random_traffic(250);

		// Sync registers change between the payload and the checksum byte.
		resync();
		p0 = rand_payload();
		p1 = rand_payload();
		send_rx(cur_sync_a);
		send_rx(cur_sync_b);
		send_rx(8'h3C);
		send_rx(8'd2);
		send_rx(p0);
		send_rx(p1);
		settle();
		write_sync(CFG_FIRST_SYNC, 8'h5A);
		write_sync(CFG_SECOND_SYNC, 8'h5A);
		send_rx(cur_sync_a + cur_sync_b + 8'h3C + 8'd2 + p0 + p1);
		random_traffic(320);

		settle();
		write_sync(CFG_FIRST_SYNC, 8'($urandom));
		write_sync(CFG_SECOND_SYNC, 8'($urandom));
		resync();
		random_traffic(380);

		settle();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.beats_owed.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
